[hdl/ircpd_pkg.sv]
// Package for the IR code pair decompressor: widths, constants and codes.
// Used by the channel interfaces and the core.
`timescale 1ns / 1ps

package ircpd_pkg;

  // Widest pair index the decoder gathers.
  localparam int MAX_INDEX_BITS = 4;

  localparam int TABLE_DEPTH  = 32;
  localparam int PAIR_DEPTH   = TABLE_DEPTH / 2;
  localparam int TABLE_AW     = $clog2(TABLE_DEPTH);
  localparam int PAIR_AW      = $clog2(PAIR_DEPTH);
  localparam int TIME_W       = 16;
  localparam int US_W         = 20;
  localparam int BYTE_W       = 8;
  localparam int BIT_POS_W    = $clog2(BYTE_W);
  localparam int BPI_W        = 3;
  localparam int PAIR_CNT_W   = 8;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 8;

  localparam logic [BPI_W-1:0]      BPI_RESET        = 3'd2;
  localparam logic [PAIR_CNT_W-1:0] PAIR_COUNT_RESET = 8'd1;

  typedef enum logic {
    OP_TABLE_WRITE = 1'b0,
    OP_CODE_BYTE   = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BITS_PER_INDEX = 1'b0,
    CFG_PAIR_COUNT     = 1'b1
  } cfg_reg_t;

endpackage

[hdl/ircpd_if.sv]
// Valid/ready channel interfaces of the IR code pair decompressor.
// Depends on ircpd_pkg for the payload widths.
`timescale 1ns / 1ps

interface ircpd_in_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic [ircpd_pkg::TABLE_AW-1:0]  table_address;
  logic [ircpd_pkg::TIME_W-1:0]    table_value;
  logic [ircpd_pkg::BYTE_W-1:0]    code_byte;

  modport source (output valid, operation, table_address, table_value, code_byte,
                  input ready);
  modport sink   (input valid, operation, table_address, table_value, code_byte,
                  output ready);
endinterface

interface ircpd_out_if;
  logic                         valid;
  logic                         ready;
  logic [ircpd_pkg::US_W-1:0]   on_time;
  logic [ircpd_pkg::US_W-1:0]   off_time;
  logic                         last_pair;

  modport source (output valid, on_time, off_time, last_pair, input ready);
  modport sink   (input valid, on_time, off_time, last_pair, output ready);
endinterface

interface ircpd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ircpd_pkg::CFG_IDX_W-1:0]   index;
  logic [ircpd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/ircpd_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; the read register holds its value while no read is issued.
`timescale 1ns / 1ps

module ircpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/ir_code_pair_decompressor_core.sv]
// IR code pair decompressor core; depends on ircpd_pkg, ircpd_if and ircpd_ram.
// Path: once an index's last bit is unpacked, its pair is read into the RAM output register
// and then moved into the output register as soon as that register is free or being read.
// Throughput: a code byte is unpacked one bit per cycle unless an output stall holds it, up
// to its eighth bit, fewer if the code's last pair ends it; one further word is held meanwhile.
// Reset clears control state, loads bits_per_index = 2 and pair_count = 1; table undefined.
`timescale 1ns / 1ps

module ir_code_pair_decompressor_core (
  input  logic        clk,
  input  logic        rst_n,
  ircpd_in_if.sink    in_chan,
  ircpd_out_if.source out_chan,
  ircpd_cfg_if.sink   cfg_chan
);
  import ircpd_pkg::*;

  // The time table is split into two banks: even words hold on times and odd
  // words hold off times, so one read address fetches a whole pair at once.

  // Configuration registers.
  logic [BPI_W-1:0]      bpi_r;
  logic [PAIR_CNT_W-1:0] pair_count_r;

  // Holding word: takes a new input word while the unpacker is still busy.
  logic                  hold_v_r;
  logic                  hold_op_r;
  logic [TABLE_AW-1:0]   hold_addr_r;
  logic [TIME_W-1:0]     hold_value_r;
  logic [BYTE_W-1:0]     hold_byte_r;

  // Current word in the unpacker.
  logic                  busy_r;
  op_t                   cur_op_r;
  logic [TABLE_AW-1:0]   cur_addr_r;
  logic [TIME_W-1:0]     cur_value_r;
  logic [BYTE_W-1:0]     sh_r;
  logic [BIT_POS_W-1:0]  pos_r;

  // Decoding state carried across bytes.
  logic [MAX_INDEX_BITS-1:0] partial_r;
  logic [BPI_W-1:0]          cnt_r;
  logic [PAIR_CNT_W-1:0]     pairs_r;

  // Read stage: a pair read is in flight or waiting in the RAM output register.
  logic                  rd_v_r;
  logic                  rd_last_r;

  // Output register.
  logic                  out_v_r;
  logic [US_W-1:0]       on_r;
  logic [US_W-1:0]       off_r;
  logic                  last_r;

  logic [TIME_W-1:0]     even_q;
  logic [TIME_W-1:0]     odd_q;

  // Combinational control.
  logic [BPI_W-1:0]          width;
  logic [MAX_INDEX_BITS-1:0] idx_mask;
  logic [MAX_INDEX_BITS:0]   shifted;
  logic [MAX_INDEX_BITS-1:0] partial_nxt;
  logic [BPI_W-1:0]          cnt_nxt;
  logic [MAX_INDEX_BITS-1:0] idx;
  logic [MAX_INDEX_BITS+PAIR_AW-1:0] idx_ext;
  logic [PAIR_AW-1:0]        raddr;
  logic [PAIR_CNT_W-1:0]     pairs_inc;
  logic                      step;
  logic                      complete;
  logic                      is_last;
  logic                      rd_move;
  logic                      issue_ok;
  logic                      advance;
  logic                      byte_done;
  logic                      done_now;
  logic                      free;
  logic                      in_acc;
  logic                      load_in;
  logic                      load_hold;
  logic                      we_even;
  logic                      we_odd;

  function automatic logic [US_W-1:0] times_ten(input logic [TIME_W-1:0] v);
    logic [US_W-1:0] w;
    w = {{(US_W - TIME_W){1'b0}}, v};
    return (w << 3) + (w << 1);
  endfunction

  // Effective index width: zero acts as one, anything above the maximum is clamped.
  always_comb begin
    width = bpi_r;
    if (bpi_r == '0) begin
      width = BPI_W'(1);
    end else if (int'(bpi_r) > MAX_INDEX_BITS) begin
      width = BPI_W'(MAX_INDEX_BITS);
    end
    idx_mask = ~({MAX_INDEX_BITS{1'b1}} << width);
  end

  // One packed bit per cycle unless a pending read stalls it, most significant first.
  assign shifted     = {partial_r, sh_r[BYTE_W-1]};
  assign partial_nxt = shifted[MAX_INDEX_BITS-1:0];
  assign cnt_nxt     = cnt_r + BPI_W'(1);
  assign complete    = (cnt_nxt >= width);
  assign idx         = partial_nxt & idx_mask;
  assign idx_ext     = {{PAIR_AW{1'b0}}, idx};
  assign raddr       = idx_ext[PAIR_AW-1:0];
  assign pairs_inc   = pairs_r + PAIR_CNT_W'(1);
  assign is_last     = complete && (pairs_inc == pair_count_r);

  // A new read may only be issued once the previous pair has left the RAM register.
  assign rd_move   = rd_v_r && (!out_v_r || out_chan.ready);
  assign issue_ok  = !rd_v_r || rd_move;
  assign step      = busy_r && (cur_op_r == OP_CODE_BYTE);
  assign advance   = step && (!complete || issue_ok);
  // The byte ends after its eighth bit, or early once the last pair of a code is out.
  assign byte_done = advance && (is_last || (pos_r == BIT_POS_W'(BYTE_W - 1)));
  assign done_now  = busy_r && ((cur_op_r == OP_TABLE_WRITE) || byte_done);
  assign free      = !busy_r || done_now;

  // No word is taken while reset is held.
  assign in_chan.ready = rst_n && !hold_v_r;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign load_hold     = hold_v_r && free;
  assign load_in       = in_acc && free;

  assign we_even = busy_r && (cur_op_r == OP_TABLE_WRITE) && !cur_addr_r[0];
  assign we_odd  = busy_r && (cur_op_r == OP_TABLE_WRITE) && cur_addr_r[0];

  ircpd_ram #(.WIDTH(TIME_W), .DEPTH(PAIR_DEPTH)) u_even_ram (
    .clk   (clk),
    .we    (we_even),
    .waddr (cur_addr_r[TABLE_AW-1:1]),
    .wdata (cur_value_r),
    .re    (advance && complete),
    .raddr (raddr),
    .rdata (even_q)
  );

  ircpd_ram #(.WIDTH(TIME_W), .DEPTH(PAIR_DEPTH)) u_odd_ram (
    .clk   (clk),
    .we    (we_odd),
    .waddr (cur_addr_r[TABLE_AW-1:1]),
    .wdata (cur_value_r),
    .re    (advance && complete),
    .raddr (raddr),
    .rdata (odd_q)
  );

  assign cfg_chan.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpi_r        <= BPI_RESET;
      pair_count_r <= PAIR_COUNT_RESET;
    end else if (cfg_chan.valid) begin
      unique case (cfg_reg_t'(cfg_chan.index))
        CFG_BITS_PER_INDEX: bpi_r        <= cfg_chan.data[BPI_W-1:0];
        CFG_PAIR_COUNT:     pair_count_r <= cfg_chan.data[PAIR_CNT_W-1:0];
      endcase
    end
  end

  // Holding word and unpacker.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r  <= 1'b0;
      busy_r    <= 1'b0;
      partial_r <= '0;
      cnt_r     <= '0;
      pairs_r   <= '0;
    end else begin
      if (in_acc && !free) begin
        hold_v_r <= 1'b1;
      end else if (load_hold) begin
        hold_v_r <= 1'b0;
      end

      if (load_hold || load_in) begin
        busy_r <= 1'b1;
      end else if (done_now) begin
        busy_r <= 1'b0;
      end

      if (advance) begin
        if (complete) begin
          partial_r <= '0;
          cnt_r     <= '0;
          pairs_r   <= is_last ? '0 : pairs_inc;
        end else begin
          partial_r <= partial_nxt;
          cnt_r     <= cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !free) begin
      hold_op_r    <= in_chan.operation;
      hold_addr_r  <= in_chan.table_address;
      hold_value_r <= in_chan.table_value;
      hold_byte_r  <= in_chan.code_byte;
    end

    if (load_hold) begin
      cur_op_r    <= op_t'(hold_op_r);
      cur_addr_r  <= hold_addr_r;
      cur_value_r <= hold_value_r;
      sh_r        <= hold_byte_r;
      pos_r       <= '0;
    end else if (load_in) begin
      cur_op_r    <= op_t'(in_chan.operation);
      cur_addr_r  <= in_chan.table_address;
      cur_value_r <= in_chan.table_value;
      sh_r        <= in_chan.code_byte;
      pos_r       <= '0;
    end else if (advance) begin
      sh_r  <= sh_r << 1;
      pos_r <= pos_r + BIT_POS_W'(1);
    end
  end

  // Read stage and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (advance && complete) begin
        rd_v_r <= 1'b1;
      end else if (rd_move) begin
        rd_v_r <= 1'b0;
      end

      if (rd_move) begin
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && complete) begin
      rd_last_r <= is_last;
    end
    if (rd_move) begin
      on_r   <= times_ten(even_q);
      off_r  <= times_ten(odd_q);
      last_r <= rd_last_r;
    end
  end

  assign out_chan.valid     = out_v_r;
  assign out_chan.on_time   = on_r;
  assign out_chan.off_time  = off_r;
  assign out_chan.last_pair = last_r;

endmodule
